// File: design/dtz_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and microcode ROM for the epoch to local date/time converter.
// Used by dtz_useq, dtz_dpath and the top level.
package dtz_pkg;

  localparam int STEP_W = 4;

  localparam logic [31:0] SEC_PER_HOUR = 32'd3600;

  // seconds / 86400 as (seconds >> 7) / 675, quotient by ceil(2^35 / 675)
  localparam logic [25:0] DAY_RECIP    = 26'd50903317;
  localparam logic [9:0]  DAY_DIV_HI   = 10'd675;
  // seconds of day / 3600 as (s >> 4) / 225, quotient by ceil(2^20 / 225)
  localparam logic [12:0] HOUR_RECIP   = 13'd4661;
  localparam logic [7:0]  HOUR_DIV_HI  = 8'd225;
  // seconds of hour / 60 as (s >> 2) / 15, quotient by ceil(2^14 / 15)
  localparam logic [10:0] MIN_RECIP    = 11'd1093;
  localparam logic [3:0]  MIN_DIV_HI   = 4'd15;

  localparam logic [11:0] YEAR_BASE    = 12'd1970;
  localparam logic [6:0]  C100_BASE    = 7'd70;
  localparam logic [8:0]  C400_BASE    = 9'd370;
  localparam logic [6:0]  C100_LAST    = 7'd99;
  localparam logic [8:0]  C400_LAST    = 9'd399;
  localparam logic [8:0]  YLEN_LEAP    = 9'd366;
  localparam logic [8:0]  YLEN_NORM    = 9'd365;

  localparam logic [3:0]  MON_JAN = 4'd0;
  localparam logic [3:0]  MON_FEB = 4'd1;
  localparam logic [3:0]  MON_APR = 4'd3;
  localparam logic [3:0]  MON_JUN = 4'd5;
  localparam logic [3:0]  MON_SEP = 4'd8;
  localparam logic [3:0]  MON_NOV = 4'd10;
  localparam logic [3:0]  MON_DEC = 4'd11;

  typedef enum logic [3:0] {
    OP_NOP     = 4'd0,
    OP_ACCEPT  = 4'd1,
    OP_DAY_Q   = 4'd2,
    OP_DAY_R   = 4'd3,
    OP_HOUR_Q  = 4'd4,
    OP_HOUR_R  = 4'd5,
    OP_MIN_Q   = 4'd6,
    OP_MIN_R   = 4'd7,
    OP_YEAR    = 4'd8,
    OP_MONTH   = 4'd9,
    OP_EMIT    = 4'd10
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER      = 3'd0,
    COND_ALWAYS     = 3'd1,
    COND_NO_INPUT   = 3'd2,
    COND_YEAR_MORE  = 3'd3,
    COND_MONTH_MORE = 3'd4,
    COND_OUT_BUSY   = 3'd5
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic no_input;
    logic year_more;
    logic month_more;
    logic out_busy;
  } stat_t;

  localparam logic [STEP_W-1:0] S_ACCEPT   = 4'd0;
  localparam logic [STEP_W-1:0] S_DAY_Q    = 4'd1;
  localparam logic [STEP_W-1:0] S_DAY_R    = 4'd2;
  localparam logic [STEP_W-1:0] S_HOUR_Q   = 4'd3;
  localparam logic [STEP_W-1:0] S_HOUR_R   = 4'd4;
  localparam logic [STEP_W-1:0] S_MIN_Q    = 4'd5;
  localparam logic [STEP_W-1:0] S_MIN_R    = 4'd6;
  localparam logic [STEP_W-1:0] S_YEAR     = 4'd7;
  localparam logic [STEP_W-1:0] S_MONTH    = 4'd8;
  localparam logic [STEP_W-1:0] S_EMIT     = 4'd9;
  localparam logic [STEP_W-1:0] S_RETURN   = 4'd10;

  function automatic ctrl_t micro_rom(logic [STEP_W-1:0] pc);
    ctrl_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, target: S_ACCEPT};
    unique case (pc)
      S_ACCEPT:   w = '{op: OP_ACCEPT, cond: COND_NO_INPUT,   target: S_ACCEPT};
      S_DAY_Q:    w = '{op: OP_DAY_Q,  cond: COND_NEVER,      target: S_ACCEPT};
      S_DAY_R:    w = '{op: OP_DAY_R,  cond: COND_NEVER,      target: S_ACCEPT};
      S_HOUR_Q:   w = '{op: OP_HOUR_Q, cond: COND_NEVER,      target: S_ACCEPT};
      S_HOUR_R:   w = '{op: OP_HOUR_R, cond: COND_NEVER,      target: S_ACCEPT};
      S_MIN_Q:    w = '{op: OP_MIN_Q,  cond: COND_NEVER,      target: S_ACCEPT};
      S_MIN_R:    w = '{op: OP_MIN_R,  cond: COND_NEVER,      target: S_ACCEPT};
      S_YEAR:     w = '{op: OP_YEAR,   cond: COND_YEAR_MORE,  target: S_YEAR};
      S_MONTH:    w = '{op: OP_MONTH,  cond: COND_MONTH_MORE, target: S_MONTH};
      S_EMIT:     w = '{op: OP_EMIT,   cond: COND_OUT_BUSY,   target: S_EMIT};
      S_RETURN:   w = '{op: OP_NOP,    cond: COND_ALWAYS,     target: S_ACCEPT};
      default:    w = '{op: OP_NOP,    cond: COND_ALWAYS,     target: S_ACCEPT};
    endcase
    return w;
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] v;
    v = 5'd31;
    unique case (m)
      MON_FEB: v = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: v = 5'd30;
      default: v = 5'd31;
    endcase
    return v;
  endfunction

endpackage

// File: design/dtz_useq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on dtz_pkg.
module dtz_useq import dtz_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t ctrl
);

  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  logic              take;

  assign ctrl = micro_rom(pc);

  always_comb begin
    unique case (ctrl.cond)
      COND_NEVER:      take = 1'b0;
      COND_ALWAYS:     take = 1'b1;
      COND_NO_INPUT:   take = stat.no_input;
      COND_YEAR_MORE:  take = stat.year_more;
      COND_MONTH_MORE: take = stat.month_more;
      COND_OUT_BUSY:   take = stat.out_busy;
      default:         take = 1'b1;
    endcase
    pc_next = take ? ctrl.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_ACCEPT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// File: design/dtz_dpath.sv
`timescale 1ns / 1ps
// Datapath: offset add, reciprocal-multiply time split, year and month walk, output register.
// Driven by control words from dtz_useq; depends on dtz_pkg.
module dtz_dpath import dtz_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_t       ctrl,
  input  logic        in_valid,
  input  logic [31:0] timestamp,
  input  logic [4:0]  utc_offset_hours,
  input  logic        out_ready,
  output stat_t       stat,
  output logic        out_valid,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second
);

  logic [31:0] lsec;
  logic [16:0] rem;
  logic [15:0] days;
  logic [11:0] yr;
  logic [6:0]  c100;
  logic [8:0]  c400;
  logic [3:0]  mon;
  logic [4:0]  hr;
  logic [5:0]  mi;
  logic [5:0]  se;

  logic [31:0] off_ext;
  logic [31:0] local_sec;
  logic [50:0] day_prod;
  logic [24:0] day_back;
  logic [24:0] day_left;
  logic [25:0] hour_prod;
  logic [12:0] hour_back;
  logic [12:0] hour_left;
  logic [20:0] min_prod;
  logic [9:0]  min_back;
  logic [9:0]  min_left;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic        out_busy;

  always_comb begin
    off_ext   = {{27{utc_offset_hours[4]}}, utc_offset_hours};
    local_sec = timestamp + off_ext * SEC_PER_HOUR;
    day_prod  = {26'd0, lsec[31:7]} * {25'd0, DAY_RECIP};
    day_back  = {9'd0, days} * {15'd0, DAY_DIV_HI};
    day_left  = lsec[31:7] - day_back;
    hour_prod = {13'd0, rem[16:4]} * {13'd0, HOUR_RECIP};
    hour_back = {8'd0, hr} * {5'd0, HOUR_DIV_HI};
    hour_left = rem[16:4] - hour_back;
    min_prod  = {11'd0, rem[11:2]} * {10'd0, MIN_RECIP};
    min_back  = {4'd0, mi} * {6'd0, MIN_DIV_HI};
    min_left  = rem[11:2] - min_back;
    leap      = (yr[1:0] == 2'd0) && ((c100 != 7'd0) || (c400 == 9'd0));
    ylen      = leap ? YLEN_LEAP : YLEN_NORM;
    mlen      = month_len(mon, leap);
    out_busy  = out_valid && !out_ready;
    stat.no_input   = !in_valid;
    stat.year_more  = days >= {7'd0, ylen};
    stat.month_more = (days >= {11'd0, mlen}) && (mon != MON_DEC);
    stat.out_busy   = out_busy;
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_ACCEPT: begin
        if (in_valid) begin
          lsec <= local_sec;
          yr   <= YEAR_BASE;
          c100 <= C100_BASE;
          c400 <= C400_BASE;
          mon  <= MON_JAN;
        end
      end
      OP_DAY_Q: begin
        days <= day_prod[50:35];
      end
      OP_DAY_R: begin
        rem <= {day_left[9:0], lsec[6:0]};
      end
      OP_HOUR_Q: begin
        hr <= hour_prod[24:20];
      end
      OP_HOUR_R: begin
        rem <= {5'd0, hour_left[7:0], rem[3:0]};
      end
      OP_MIN_Q: begin
        mi <= min_prod[19:14];
      end
      OP_MIN_R: begin
        se <= {min_left[3:0], rem[1:0]};
      end
      OP_YEAR: begin
        if (stat.year_more) begin
          days <= days - {7'd0, ylen};
          yr   <= yr + 1'b1;
          c100 <= (c100 == C100_LAST) ? 7'd0 : c100 + 1'b1;
          c400 <= (c400 == C400_LAST) ? 9'd0 : c400 + 1'b1;
        end
      end
      OP_MONTH: begin
        if (stat.month_more) begin
          days <= days - {11'd0, mlen};
          mon  <= mon + 1'b1;
        end
      end
      OP_EMIT: begin
        if (!out_busy) begin
          year   <= yr;
          month  <= mon + 1'b1;
          day    <= days[4:0] + 1'b1;
          hour   <= hr;
          minute <= mi;
          second <= se;
        end
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == OP_EMIT && !out_busy) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: design/epoch_to_datetime_with_timezone.sv
`timescale 1ns / 1ps
// Converts a Unix timestamp plus a whole-hour UTC offset into local Gregorian date and time.
// Top level; instantiates dtz_useq and dtz_dpath, depends on dtz_pkg.
//
// One transaction at a time: the block takes a timestamp and a signed hour offset, adds
// offset * 3600 modulo 2^32, and returns year, month, day, hour, minute and second of the
// civil calendar. After acceptance the microcoded datapath splits off days, hours, minutes
// and seconds by reciprocal multiplication, then walks the years, one calendar year per
// cycle, and then the months before the result is offered. Input is ready again once the
// sequencer has gone from the emit step through the return step back to the accept step.
// A finished result waits in the output register while the next transaction is accepted;
// the next result then holds until the output register is free.
module epoch_to_datetime_with_timezone import dtz_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] timestamp,
  input  logic [4:0]  utc_offset_hours,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second
);

  ctrl_t ctrl;
  stat_t stat;

  assign in_ready = (ctrl.op == OP_ACCEPT) && !rst;

  dtz_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  dtz_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .ctrl             (ctrl),
    .in_valid         (in_valid),
    .timestamp        (timestamp),
    .utc_offset_hours (utc_offset_hours),
    .out_ready        (out_ready),
    .stat             (stat),
    .out_valid        (out_valid),
    .year             (year),
    .month            (month),
    .day              (day),
    .hour             (hour),
    .minute           (minute),
    .second           (second)
  );

endmodule

// File: design/dtz_check.sv
`timescale 1ns / 1ps
// Port-level checker for epoch_to_datetime_with_timezone, attached by bind.
// Depends only on the top-level ports.
module dtz_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [31:0] timestamp,
  input logic [4:0]  utc_offset_hours,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] year,
  input logic [3:0]  month,
  input logic [4:0]  day,
  input logic [4:0]  hour,
  input logic [5:0]  minute,
  input logic [5:0]  second
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second transaction while converting");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(year) && $stable(month) && $stable(day))
    else $error("result dropped or changed while stalled");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> month >= 4'd1 && month <= 4'd12 && day >= 5'd1 && day <= 5'd31
                  && year >= 12'd1970 && year <= 12'd2106)
    else $error("date field out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59)
    else $error("time field out of range");

endmodule

bind epoch_to_datetime_with_timezone dtz_check u_dtz_check (.*);
